>>> src/idst_pkg.sv
// ----------------------------------------------------------------------------
// idst_pkg: shared definitions for the id set table
// Command codes, field widths, defaults and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package idst_pkg;

  // field widths fixed by the interface
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned COUNT_W = 5;

  // default table capacity
  localparam int unsigned SLOTS_DEF = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

  // reset value of the reserved id register
  localparam logic [ID_W-1:0] MARKER_RST = 32'hFFFF_FFFF;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture a new request, restart the scan
    logic scan_en;  // walk the slots
    logic out_load; // move the result into the output register
  } ctrl_t;

  // datapath -> controller status
  typedef struct packed {
    logic reject;    // incoming request is invalid (bad code or reserved id)
    logic scan_done; // scan found its slot or ran past the last one
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

>>> src/id_set_table_unit.sv
// ----------------------------------------------------------------------------
// id_set_table_unit: fixed-capacity set of 32-bit identifiers
// Add, delete and find requests against SLOTS slots, one result per request.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   input     in_valid_i / in_stall_o   cmd_i, id_i
//   result    out_valid_o / out_stall_i status_o, found_o, count_o
//   register  cfg_we_i                  cfg_wdata_i (reserved id)
//
// The slot scan reads one slot of the slot memory per cycle through its
// single read port and stops at the first slot that qualifies. A request
// with a bad code or the reserved id skips the scan. After reset all slots
// are empty (valid bits clear), no clearing pass. A new request is taken
// while the previous result still waits in the output register; a stalled
// result holds the sequencer in its final step only.
// ----------------------------------------------------------------------------
module id_set_table_unit #(
  parameter int unsigned SLOTS = idst_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [idst_pkg::CMD_W-1:0]    cmd_i,
  input  logic [idst_pkg::ID_W-1:0]     id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic                          found_o,
  output logic [idst_pkg::COUNT_W-1:0]  count_o,
  input  logic                          cfg_we_i,
  input  logic [idst_pkg::ID_W-1:0]     cfg_wdata_i
);

  idst_pkg::ctrl_t ctrl;
  idst_pkg::stat_t stat;

  // sequencer
  idst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // slot store and scan
  idst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .id_i        (id_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .count_o     (count_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

>>> src/idst_ctrl.sv
// ----------------------------------------------------------------------------
// idst_ctrl: request sequencer for the id set table
// Takes one request at a time, runs the slot scan and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module idst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  idst_pkg::stat_t stat_i,
  output idst_pkg::ctrl_t ctrl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d         = state_q;
    ctrl_o.load     = 1'b0;
    ctrl_o.scan_en  = 1'b0;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          state_d     = stat_i.reject ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("controller stayed idle after a transfer");

  // a result handed to a free output register returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && stat_i.out_free) |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after result");
`endif

endmodule

>>> src/idst_dp.sv
// ----------------------------------------------------------------------------
// idst_dp: datapath of the id set table
// Slot memory with per-slot valid bits, one-slot-per-cycle scan, occupancy
// count, reserved id register and the output register.
// ----------------------------------------------------------------------------
module idst_dp #(
  parameter int unsigned SLOTS = idst_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request fields
  input  logic [idst_pkg::CMD_W-1:0]    cmd_i,
  input  logic [idst_pkg::ID_W-1:0]     id_i,
  // register write
  input  logic                          cfg_we_i,
  input  logic [idst_pkg::ID_W-1:0]     cfg_wdata_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic                          found_o,
  output logic [idst_pkg::COUNT_W-1:0]  count_o,
  // controller link
  input  idst_pkg::ctrl_t               ctrl_i,
  output idst_pkg::stat_t               stat_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

  // slot storage
  logic [idst_pkg::ID_W-1:0]  mem [SLOTS];
  logic [SLOTS-1:0]           valid_q;
  logic [CW-1:0]              count_q;
  logic [idst_pkg::ID_W-1:0]  marker_q;

  // request registers
  logic [idst_pkg::CMD_W-1:0] cmd_q;
  logic [idst_pkg::ID_W-1:0]  id_q;

  // scan pipeline
  logic [IW-1:0]              rd_idx_q;
  logic                       rd_go_q;
  logic                       cmp_vld_q;
  logic [IW-1:0]              cmp_idx_q;
  logic [idst_pkg::ID_W-1:0]  rdata_q;
  logic                       rd_en;
  logic                       hit;
  logic                       scan_end;
  logic                       commit;

  // result and output registers
  logic                       res_status_q;
  logic                       res_found_q;
  logic                       out_valid_q;
  logic                       out_status_q;
  logic                       out_found_q;
  logic [idst_pkg::COUNT_W-1:0] out_count_q;

  // reserved id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= idst_pkg::MARKER_RST;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  // capture request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      id_q  <= id_i;
    end
  end

  // read side of the scan: one slot address per cycle
  assign rd_en = ctrl_i.scan_en && rd_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      rd_go_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else if (ctrl_i.load) begin
      rd_idx_q  <= '0;
      rd_go_q   <= 1'b1;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        if (rd_idx_q == LAST_IDX) begin
          rd_go_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q   <= mem[rd_idx_q];
      cmp_idx_q <= rd_idx_q;
    end
  end

  // compare stage: add looks for a free slot, delete and find for a match
  always_comb begin
    if (cmd_q == idst_pkg::CMD_ADD) begin
      hit = cmp_vld_q && !valid_q[cmp_idx_q];
    end else begin
      hit = cmp_vld_q && valid_q[cmp_idx_q] && (rdata_q == id_q);
    end
  end

  assign scan_end = ctrl_i.scan_en && cmp_vld_q && (hit || (cmp_idx_q == LAST_IDX));
  assign commit   = ctrl_i.scan_en && hit && (cmd_q != idst_pkg::CMD_FIND);

  // slot memory write on add or delete
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[cmp_idx_q] <= (cmd_q == idst_pkg::CMD_ADD) ? id_q : marker_q;
    end
  end

  // valid bits and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (commit) begin
      if (cmd_q == idst_pkg::CMD_ADD) begin
        valid_q[cmp_idx_q] <= 1'b1;
        count_q            <= count_q + 1'b1;
      end else begin
        valid_q[cmp_idx_q] <= 1'b0;
        count_q            <= count_q - 1'b1;
      end
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_status_q <= 1'b1;
      res_found_q  <= 1'b0;
    end else if (scan_end) begin
      res_status_q <= (cmd_q != idst_pkg::CMD_FIND) && !hit;
      res_found_q  <= (cmd_q == idst_pkg::CMD_FIND) && hit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_count_q  <= idst_pkg::COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign count_o     = out_count_q;

  // status to the controller
  assign stat_o.reject    = (cmd_i != idst_pkg::CMD_ADD) && (cmd_i != idst_pkg::CMD_DEL) &&
                            (cmd_i != idst_pkg::CMD_FIND) || (id_i == marker_q);
  assign stat_o.scan_done = scan_end;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

`ifndef NO_ASSERTIONS
  // occupancy always matches the valid bits
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q) == int'(count_q)))
    else $error("occupancy count out of step with valid bits");

  // an add only ever lands when the table has room
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && cmd_q == idst_pkg::CMD_ADD) |-> (count_q != FULL_CNT))
    else $error("add committed into a full table");
`endif

endmodule

>>> dv/id_set_table_checker.sv
// ----------------------------------------------------------------------------
// id_set_table_checker: result predictor and scoreboard for id_set_table_unit
// Watches the request, result and register ports. Each accepted request is
// run against a private copy of the slot table and the expected result is
// queued; each accepted result is compared field by field with the oldest
// queued one. Failure and activity counts go back to the testbench top.
// ----------------------------------------------------------------------------
module id_set_table_checker
  import idst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               status_i,
  input  logic               found_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic               cfg_we_i,
  input  logic [ID_W-1:0]    cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        results_o,
  output int unsigned        rejects_o,
  output int unsigned        hits_o,
  output int unsigned        peak_count_o
);

  typedef struct packed {
    logic               status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  // shadow copy of the table
  logic [ID_W-1:0]    slot_id [SLOTS];
  logic [SLOTS-1:0]   slot_used;
  logic [COUNT_W-1:0] occupancy;
  logic [ID_W-1:0]    reserved_id;

  set_result_t expected_results[$];
  int unsigned fails   = 0;
  int unsigned results = 0;
  int unsigned rejects = 0;
  int unsigned hits    = 0;
  int unsigned peak    = 0;

  // lowest used slot holding v, -1 if none
  function automatic int match_slot(input logic [ID_W-1:0] v);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_id[i] == v) return i;
    end
    return -1;
  endfunction

  // lowest unused slot, -1 when full
  function automatic int open_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) return i;
    end
    return -1;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic set_result_t apply_request(input logic [CMD_W-1:0] c,
                                                input logic [ID_W-1:0]  v);
    set_result_t res;
    int          s;
    res = '0;
    if (v == reserved_id) begin
      res.status = 1'b1;
    end else begin
      case (c)
        CMD_ADD: begin
          s = open_slot();
          if (s < 0) begin
            res.status = 1'b1;
          end else begin
            slot_id[s]   = v;
            slot_used[s] = 1'b1;
            occupancy    = occupancy + 1'b1;
          end
        end
        CMD_DEL: begin
          s = match_slot(v);
          if (s < 0) begin
            res.status = 1'b1;
          end else begin
            slot_id[s]   = reserved_id;
            slot_used[s] = 1'b0;
            occupancy    = occupancy - 1'b1;
          end
        end
        CMD_FIND: begin
          res.found = (match_slot(v) >= 0);
        end
        default: begin
          res.status = 1'b1;
        end
      endcase
    end
    res.count = occupancy;
    return res;
  endfunction

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    set_result_t want;
    if (!rst_ni) begin
      slot_used   = '0;
      occupancy   = '0;
      reserved_id = MARKER_RST;
      expected_results.delete();
    end else begin
      // a result always belongs to an earlier request, so retire it first
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d found %0d count %0d",
                   $realtime, status_i, found_i, count_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) report("status", want.status, status_i);
          if (found_i !== want.found) report("found", want.found, found_i);
          if (count_i !== want.count) report("count", want.count, count_i);
          if (want.status) rejects++;
          if (want.found) hits++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_request(cmd_i, id_i));
        if (occupancy > peak) peak = occupancy;
      end
      if (cfg_we_i) reserved_id = cfg_wdata_i;
    end
    // registered so the top reads them free of races
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    results_o    <= results;
    rejects_o    <= rejects;
    hits_o       <= hits;
    peak_count_o <= peak;
  end

endmodule

>>> dv/id_set_table_unit_test.sv
// ----------------------------------------------------------------------------
// id_set_table_unit_test: testbench top for id_set_table_unit
// Directed requests for the corner cases (empty, duplicate, full, reserved
// id, unused code, reserved id moved onto a stored id), then random phases
// under several reserved-id settings with bursty requests and back-pressure.
// Checking is done by id_set_table_checker; this module drives and judges.
// ----------------------------------------------------------------------------
module id_set_table_unit_test;
  import idst_pkg::*;

  localparam int unsigned SLOTS       = SLOTS_DEF;
  localparam int unsigned SCAN_CYCLES = SLOTS + 3;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned POOL_SIZE   = 8;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 205;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd       = CMD_FIND;
  logic [ID_W-1:0]    id        = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic               found;
  logic [COUNT_W-1:0] count;
  logic               cfg_we    = 1'b0;
  logic [ID_W-1:0]    cfg_wdata = MARKER_RST;

  int unsigned fail_count, pending, n_results, n_rejects, n_hits, peak;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_mode = 0;
  int unsigned burst_left = 0;
  bit          gapless    = 1'b0;
  bit          add_heavy  = 1'b1;
  logic [ID_W-1:0] marker = MARKER_RST;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  always #5 clk = ~clk;

  id_set_table_unit #(.SLOTS(SLOTS)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .cmd_i      (cmd),
    .id_i       (id),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .found_o    (found),
    .count_o    (count),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  id_set_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cmd_i       (cmd),
    .id_i        (id),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .status_i    (status),
    .found_i     (found),
    .count_i     (count),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (n_results),
    .rejects_o   (n_rejects),
    .hits_o      (n_hits),
    .peak_count_o(peak)
  );

  // result back-pressure in one of four randomly chosen styles
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_cnt % 11) < 4;
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one request transfer, then maybe a gap at the end of a burst
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] v);
    int unsigned gap;
    in_valid <= 1'b1;
    cmd      <= c;
    id       <= v;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = gapless ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 11);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait for every outstanding result, then allow a full scan
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [ID_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    marker = v;
  endtask

  // random request: pool ids give hits, the marker gives rejects
  task automatic random_request();
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0]  v;
    int unsigned      r;
    r = $urandom_range(0, 99);
    if (r < 3) c = CMD_UNUSED;
    else if (r < (add_heavy ? 63 : 23)) c = CMD_ADD;
    else if (r < (add_heavy ? 80 : 78)) c = CMD_DEL;
    else c = CMD_FIND;
    r = $urandom_range(0, 99);
    if (r < 8) v = marker;
    else if (r < 75) v = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else v = $urandom();
    send_request(c, v);
  endtask

  initial begin : stimulus
    logic [ID_W-1:0] phase_marker [PHASES];
    id_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_A5A5, 32'h0000_FFFF};
    phase_marker[0] = 32'h0000_0000;
    phase_marker[1] = id_pool[$urandom_range(2, POOL_SIZE - 1)];
    phase_marker[2] = 32'h8000_0000;
    phase_marker[3] = $urandom();
    phase_marker[4] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases on the reset marker
    send_request(CMD_FIND, 32'h0);        // empty table
    send_request(CMD_DEL, 32'h0);         // not present
    send_request(CMD_ADD, MARKER_RST);    // reserved id
    send_request(CMD_UNUSED, 32'h1);
    send_request(CMD_ADD, 32'h0);
    send_request(CMD_ADD, 32'h0);         // duplicate accepted
    send_request(CMD_DEL, 32'h0);         // removes the lower copy only
    send_request(CMD_FIND, 32'h0);        // other copy still there
    for (int i = 0; i < SLOTS - 1; i++) begin
      send_request(CMD_ADD, (i == 0) ? 32'hFFFF_FFFE : $urandom());
    end
    send_request(CMD_ADD, 32'h1);         // table full
    settle();

    // reserved id moved onto a stored id: still a member, but rejected
    write_marker(phase_marker[0]);
    send_request(CMD_FIND, 32'h0);
    send_request(CMD_ADD, 32'h0);
    send_request(CMD_DEL, 32'hFFFF_FFFE);

    // random phases, one per marker setting
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_marker(phase_marker[p]);
        for (int k = POOL_SIZE / 2; k < POOL_SIZE; k++) id_pool[k] = $urandom();
      end
      gapless = (p % 2 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) add_heavy = ~add_heavy;
        random_request();
      end
    end
    settle();

    $display("Checked %0d results across %0d reserved-id settings: %0d rejected, %0d find hits.",
             n_results, PHASES + 1, n_rejects, n_hits);
    $display("Occupancy reached %0d of %0d slots.", peak, SLOTS);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
